// File: rtl/fisc_pkg.sv
`default_nettype none

package fisc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [WORD_W-1:0] DEFAULT_ID      = 32'h6572_d028;
    localparam logic [WORD_W-1:0] DEFAULT_VERSION = 32'd4;
    localparam logic [WORD_W-1:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] HEADER_LEN      = 32'd16;
    localparam logic [WORD_W-1:0] CRC_LEN         = 32'd4;

    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_ID      = 1'd0,
        CFG_EXPECTED_VERSION = 1'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        KIND_HEADER    = 4'd0,
        KIND_KEY       = 4'd1,
        KIND_VALUE     = 4'd2,
        KIND_PAIR_END  = 4'd3,
        KIND_SEPARATOR = 4'd4,
        KIND_PAYLOAD   = 4'd5,
        KIND_CRC       = 4'd6,
        KIND_IGNORED   = 4'd7,
        KIND_END       = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_BAD_ID    = 3'd1,
        VERDICT_BAD_VER   = 3'd2,
        VERDICT_BAD_LAYOUT = 3'd3,
        VERDICT_CRC_BAD   = 3'd4,
        VERDICT_TRUNCATED = 3'd5
    } verdict_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  byte_value;
        logic               verdict_valid;
        verdict_t           verdict;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/fisc_crc8.sv
`default_nettype none

module fisc_crc8
    import fisc_pkg::*;
(
    input  wire logic [WORD_W-1:0] crc_in,
    input  wire logic [BYTE_W-1:0] data_in,
    output logic      [WORD_W-1:0] crc_out
);

    // reflected crc-32, one byte unrolled into xor logic
    always_comb
    begin
        logic [WORD_W-1:0] c;
        logic [BYTE_W-1:0] d;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if ((c[0] ^ d[0]) == 1'b1)
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// File: rtl/fisc_core.sv
`default_nettype none

module fisc_core
    import fisc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              end_of_stream,
    input  wire logic [WORD_W-1:0] expected_id,
    input  wire logic [WORD_W-1:0] expected_version,
    output result_t                result
);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_META    = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CRC     = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        MS_KEY   = 4'b0001,
        MS_SEP   = 4'b0010,
        MS_VALUE = 4'b0100,
        MS_EOL   = 4'b1000
    } meta_state_t;

    phase_t            phase_reg, phase_next;
    meta_state_t       meta_reg, meta_next;
    logic [WORD_W-1:0] pos_reg, pos_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] size_reg, size_next;
    logic [WORD_W-1:0] offset_reg, offset_next;
    logic [WORD_W-1:0] remaining_reg, remaining_next;
    logic [WORD_W-1:0] crc_reg, crc_next;
    logic              given_reg, given_next;

    logic [WORD_W-1:0] crc_fed;
    logic [WORD_W-1:0] shift_fed;
    logic [WORD_W-1:0] pos_inc;
    logic [WORD_W-1:0] rem_calc;
    logic              layout_bad;
    logic              line_end;

    fisc_crc8 u_crc8 (
        .crc_in  (crc_reg),
        .data_in (data_byte),
        .crc_out (crc_fed)
    );

    assign shift_fed  = {shift_reg[WORD_W-BYTE_W-1:0], data_byte};
    assign pos_inc    = pos_reg + 32'd1;
    assign rem_calc   = size_reg - shift_fed - CRC_LEN;
    assign layout_bad = (shift_fed < HEADER_LEN)
                     || ({1'b0, size_reg} < ({1'b0, shift_fed} + {1'b0, CRC_LEN}));
    assign line_end   = (data_byte == CHAR_LF) || (data_byte == CHAR_CR)
                     || (data_byte == CHAR_NUL);

    always_comb
    begin
        meta_state_t ms;
        phase_next     = phase_reg;
        meta_next      = meta_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        size_next      = size_reg;
        offset_next    = offset_reg;
        remaining_next = remaining_reg;
        crc_next       = crc_reg;
        given_next     = given_reg;
        ms             = meta_reg;

        result.kind          = KIND_IGNORED;
        result.byte_value    = data_byte;
        result.verdict_valid = 1'b0;
        result.verdict       = VERDICT_OK;

        if (end_of_stream)
        begin
            result.kind          = KIND_END;
            result.byte_value    = '0;
            result.verdict_valid = !given_reg;
            result.verdict       = given_reg ? VERDICT_OK : VERDICT_TRUNCATED;
            phase_next     = PH_HEADER;
            meta_next      = MS_KEY;
            pos_next       = '0;
            shift_next     = '0;
            size_next      = '0;
            offset_next    = '0;
            remaining_next = '0;
            crc_next       = CRC_INIT;
            given_next     = 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    result.kind = KIND_HEADER;
                    crc_next    = crc_fed;
                    shift_next  = shift_fed;
                    pos_next    = pos_inc;
                    if (pos_reg == 32'd3)
                    begin
                        if (shift_fed != expected_id)
                        begin
                            result.verdict_valid = 1'b1;
                            result.verdict       = VERDICT_BAD_ID;
                        end
                    end
                    else if (pos_reg == 32'd7)
                    begin
                        size_next = shift_fed;
                    end
                    else if (pos_reg == 32'd11)
                    begin
                        if (shift_fed != expected_version)
                        begin
                            result.verdict_valid = 1'b1;
                            result.verdict       = VERDICT_BAD_VER;
                        end
                    end
                    else if (pos_reg == 32'd15)
                    begin
                        offset_next = shift_fed;
                        if (layout_bad)
                        begin
                            result.verdict_valid = 1'b1;
                            result.verdict       = VERDICT_BAD_LAYOUT;
                        end
                        else
                        begin
                            remaining_next = rem_calc;
                        end
                    end

                    if (result.verdict_valid)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (pos_inc == HEADER_LEN)
                    begin
                        // offset word was completed by this byte
                        if (shift_fed == HEADER_LEN)
                        begin
                            if (rem_calc != '0)
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = PH_CRC;
                                pos_next   = '0;
                            end
                        end
                        else
                        begin
                            phase_next = PH_META;
                        end
                    end
                end

                PH_META:
                begin
                    crc_next = crc_fed;
                    pos_next = pos_inc;
                    if ((meta_reg == MS_EOL) && line_end)
                    begin
                        result.kind = KIND_PAIR_END;
                    end
                    else
                    begin
                        if (meta_reg == MS_EOL)
                        begin
                            ms = MS_KEY;
                        end
                        meta_next = ms;
                        case (ms)
                            MS_KEY:
                            begin
                                if (data_byte == CHAR_COLON)
                                begin
                                    result.kind = KIND_SEPARATOR;
                                    meta_next   = MS_SEP;
                                end
                                else
                                begin
                                    result.kind = KIND_KEY;
                                end
                            end
                            MS_SEP:
                            begin
                                result.kind = KIND_SEPARATOR;
                                if (data_byte == CHAR_SPACE)
                                begin
                                    meta_next = MS_VALUE;
                                end
                            end
                            MS_VALUE:
                            begin
                                if (line_end)
                                begin
                                    result.kind = KIND_PAIR_END;
                                    meta_next   = MS_EOL;
                                end
                                else
                                begin
                                    result.kind = KIND_VALUE;
                                end
                            end
                            default:
                            begin
                                result.kind = KIND_PAIR_END;
                            end
                        endcase
                    end
                    if (pos_inc >= offset_reg)
                    begin
                        if (remaining_reg != '0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = PH_CRC;
                            pos_next   = '0;
                        end
                    end
                end

                PH_PAYLOAD:
                begin
                    result.kind    = KIND_PAYLOAD;
                    crc_next       = crc_fed;
                    remaining_next = remaining_reg - 32'd1;
                    if (remaining_reg == 32'd1)
                    begin
                        phase_next = PH_CRC;
                        pos_next   = '0;
                    end
                end

                PH_CRC:
                begin
                    result.kind = KIND_CRC;
                    shift_next  = shift_fed;
                    pos_next    = pos_inc;
                    if (pos_inc >= CRC_LEN)
                    begin
                        result.verdict_valid = 1'b1;
                        result.verdict = (shift_fed == ~crc_reg) ? VERDICT_OK
                                                                 : VERDICT_CRC_BAD;
                        phase_next = PH_DONE;
                    end
                end

                default:
                begin
                    result.kind = KIND_IGNORED;
                end
            endcase

            if (result.verdict_valid)
            begin
                given_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            meta_reg      <= MS_KEY;
            pos_reg       <= '0;
            shift_reg     <= '0;
            size_reg      <= '0;
            offset_reg    <= '0;
            remaining_reg <= '0;
            crc_reg       <= CRC_INIT;
            given_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            meta_reg      <= meta_next;
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            size_reg      <= size_next;
            offset_reg    <= offset_next;
            remaining_reg <= remaining_next;
            crc_reg       <= crc_next;
            given_reg     <= given_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/firmware_image_stream_checker.sv
// a word accepted on the input passes through the input register and then the result register to the output
// throughput: one word per cycle, sustained while m_tready stays high
// the input register and the result register each keep a word while the result register is full and m_tready is low
// reset (rst_n low, asynchronous): parser back to the header phase, crc to all ones,
// both register stages empty, expected id and version back to their defaults
`default_nettype none

module firmware_image_stream_checker
    import fisc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // data_byte
    input  wire logic                 s_tuser,   // end_of_stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,   // byte_value, verdict, zero pad
    output logic [4:0]                m_tuser,   // kind, verdict_valid
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           result;
    logic              out_ready;
    logic              advance;
    logic [WORD_W-1:0] expected_id_reg;
    logic [WORD_W-1:0] expected_version_reg;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg      <= DEFAULT_ID;
            expected_version_reg <= DEFAULT_VERSION;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_ID:      expected_id_reg      <= cfg_data;
                CFG_EXPECTED_VERSION: expected_version_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tuser;
        end
    end

    fisc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .advance          (advance),
        .data_byte        (in_byte_reg),
        .end_of_stream    (in_eos_reg),
        .expected_id      (expected_id_reg),
        .expected_version (expected_version_reg),
        .result           (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.verdict, out_reg.byte_value};
    assign m_tuser  = {out_reg.verdict_valid, out_reg.kind};

endmodule

`default_nettype wire

// File: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fisc_pkg::*;

    class image_tag_board;
        typedef enum {IMG_HEADER, IMG_META, IMG_PAYLOAD, IMG_CRC, IMG_DONE} img_step_e;
        typedef enum {TXT_KEY, TXT_SEP, TXT_VALUE, TXT_EOL} txt_state_e;

        logic [31:0] want_id;
        logic [31:0] want_version;
        img_step_e   step;
        txt_state_e  txt;
        logic [31:0] pos;
        logic [31:0] shift;
        logic [31:0] file_size;
        logic [31:0] data_offset;
        logic [31:0] remaining;
        logic [31:0] crc;
        bit          given;
        result_t     pending_tags[$];
        int          errors;

        function new();
            want_id = DEFAULT_ID;
            want_version = DEFAULT_VERSION;
            errors = 0;
            restart();
        endfunction

        function void restart();
            step = IMG_HEADER;
            txt = TXT_KEY;
            pos = '0;
            shift = '0;
            file_size = '0;
            data_offset = '0;
            remaining = '0;
            crc = CRC_INIT;
            given = 1'b0;
        endfunction

        static function logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
            for (int i = 0; i < 8; i++)
            begin
                if (c[0] ^ b[i])
                    c = (c >> 1) ^ CRC_POLY;
                else
                    c = c >> 1;
            end
            return c;
        endfunction

        function bit line_end(logic [7:0] b);
            return b == CHAR_CR || b == CHAR_LF || b == CHAR_NUL;
        endfunction

        function kind_t text_kind(logic [7:0] b);
            if (txt == TXT_EOL)
            begin
                if (line_end(b))
                    return KIND_PAIR_END;
                txt = TXT_KEY;
            end
            case (txt)
                TXT_KEY:
                begin
                    if (b == CHAR_COLON)
                    begin
                        txt = TXT_SEP;
                        return KIND_SEPARATOR;
                    end
                    return KIND_KEY;
                end
                TXT_SEP:
                begin
                    if (b == CHAR_SPACE)
                        txt = TXT_VALUE;
                    return KIND_SEPARATOR;
                end
                default:
                begin
                    if (line_end(b))
                    begin
                        txt = TXT_EOL;
                        return KIND_PAIR_END;
                    end
                    return KIND_VALUE;
                end
            endcase
        endfunction

        function void enter_body();
            if (remaining != 0)
                step = IMG_PAYLOAD;
            else
            begin
                step = IMG_CRC;
                pos = '0;
            end
        endfunction

        function void set_reg(cfg_index_t idx, logic [31:0] v);
            if (idx == CFG_EXPECTED_ID)
                want_id = v;
            else
                want_version = v;
        endfunction

        function void note_word(logic [7:0] b, logic eos);
            result_t r;
            r.kind = KIND_IGNORED;
            r.byte_value = b;
            r.verdict_valid = 1'b0;
            r.verdict = VERDICT_OK;
            if (eos)
            begin
                r.kind = KIND_END;
                r.byte_value = '0;
                r.verdict_valid = !given;
                r.verdict = given ? VERDICT_OK : VERDICT_TRUNCATED;
                restart();
                pending_tags = {pending_tags, r};
                return;
            end
            case (step)
                IMG_HEADER:
                begin
                    r.kind = KIND_HEADER;
                    crc = crc_byte(crc, b);
                    shift = {shift[23:0], b};
                    case (pos)
                        32'd3:
                            if (shift != want_id)
                            begin
                                r.verdict_valid = 1'b1;
                                r.verdict = VERDICT_BAD_ID;
                            end
                        32'd7:
                            file_size = shift;
                        32'd11:
                            if (shift != want_version)
                            begin
                                r.verdict_valid = 1'b1;
                                r.verdict = VERDICT_BAD_VER;
                            end
                        32'd15:
                        begin
                            data_offset = shift;
                            if (data_offset < HEADER_LEN ||
                                {32'd0, file_size} < {32'd0, data_offset} + 64'd4)
                            begin
                                r.verdict_valid = 1'b1;
                                r.verdict = VERDICT_BAD_LAYOUT;
                            end
                            else
                                remaining = file_size - data_offset - CRC_LEN;
                        end
                        default:
                            ;
                    endcase
                    pos++;
                    if (r.verdict_valid)
                        step = IMG_DONE;
                    else if (pos == HEADER_LEN)
                    begin
                        if (data_offset == HEADER_LEN)
                            enter_body();
                        else
                            step = IMG_META;
                    end
                end
                IMG_META:
                begin
                    crc = crc_byte(crc, b);
                    r.kind = text_kind(b);
                    pos++;
                    if (pos >= data_offset)
                        enter_body();
                end
                IMG_PAYLOAD:
                begin
                    r.kind = KIND_PAYLOAD;
                    crc = crc_byte(crc, b);
                    remaining--;
                    if (remaining == 0)
                    begin
                        step = IMG_CRC;
                        pos = '0;
                    end
                end
                IMG_CRC:
                begin
                    r.kind = KIND_CRC;
                    shift = {shift[23:0], b};
                    pos++;
                    if (pos >= CRC_LEN)
                    begin
                        r.verdict_valid = 1'b1;
                        r.verdict = (shift == ~crc) ? VERDICT_OK : VERDICT_CRC_BAD;
                        step = IMG_DONE;
                    end
                end
                default:
                    ;
            endcase
            if (r.verdict_valid)
                given = 1'b1;
            pending_tags = {pending_tags, r};
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100)
                $display("%0t mismatch: %s", $time, what);
        endtask

        task check_word(logic [15:0] data, logic [4:0] user);
            result_t want;
            if (pending_tags.size() == 0)
            begin
                report($sformatf("word with nothing pending, kind %0d byte %02h",
                                 user[3:0], data[7:0]));
                return;
            end
            want = pending_tags.pop_front();
            if (user[3:0] != want.kind)
                report($sformatf("kind %0d, want %0d", user[3:0], want.kind));
            if (data[7:0] != want.byte_value)
                report($sformatf("byte %02h, want %02h", data[7:0], want.byte_value));
            if (user[4] != want.verdict_valid)
                report($sformatf("verdict_valid %0b, want %0b", user[4], want.verdict_valid));
            if (data[10:8] != want.verdict)
                report($sformatf("verdict %0d, want %0d", data[10:8], want.verdict));
        endtask
    endclass

    typedef enum {FLAW_NONE, FLAW_CRC, FLAW_ID, FLAW_VERSION, FLAW_LAYOUT, FLAW_NOISE} flaw_e;

    localparam int IDLE_LIMIT = 1000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic [4:0]           m_tuser;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_EXPECTED_ID;
    logic [WORD_W-1:0]    cfg_data = '0;

    image_tag_board sb = new();
    logic [7:0]     image[$];
    int             items_sent = 0;
    bit             steady = 1'b0;
    bit             tail_part = 1'b0;
    int             sink_hold = 0;
    int             idle_cycles = 0;

    firmware_image_stream_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (sink_hold != 0)
            sink_hold <= sink_hold - 1;
        else if (tail_part || steady || !m_tready || $urandom_range(0, 2) != 0)
        begin
            m_tready <= 1'b1;
            sink_hold <= (tail_part || steady) ? 0 : $urandom_range(0, 29);
        end
        else
        begin
            m_tready <= 1'b0;
            sink_hold <= $urandom_range(0, 11);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic void push_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            image = {image, w[8*i +: 8]};
    endfunction

    function automatic void make_image(flaw_e flaw, int unsigned meta_len, int unsigned body_len);
        logic [31:0] id;
        logic [31:0] ver;
        logic [31:0] offset;
        logic [31:0] total;
        logic [31:0] sum;
        logic [7:0]  txt[$];
        logic [7:0]  eol[3];
        eol = '{CHAR_CR, CHAR_LF, CHAR_NUL};
        image.delete();
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 30))
                image = {image, 8'($urandom)};
            return;
        end
        id = sb.want_id;
        ver = sb.want_version;
        offset = HEADER_LEN + meta_len;
        total = offset + body_len + CRC_LEN;
        if (flaw == FLAW_ID)
            id ^= 32'd1 << $urandom_range(0, 31);
        if (flaw == FLAW_VERSION)
            ver ^= 32'd1 << $urandom_range(0, 31);
        if (flaw == FLAW_LAYOUT)
            case ($urandom_range(0, 2))
                0: offset = $urandom_range(0, 15);
                1: total = offset + $urandom_range(0, 3);
                default:
                begin
                    // offset + 4 runs past 32 bits
                    offset = 32'hFFFF_FFFC + $urandom_range(0, 3);
                    total = 32'hFFFF_FFFF - $urandom_range(0, 1);
                end
            endcase
        push_word(id);
        push_word(total);
        push_word(ver);
        push_word(offset);
        // key: value lines, with a stray byte now and then
        while (txt.size() < meta_len)
        begin
            repeat ($urandom_range(1, 5))
                txt = {txt, 8'($urandom_range(8'h21, 8'h7E))};
            txt = {txt, CHAR_COLON};
            if ($urandom_range(0, 3) == 0)
                txt = {txt, 8'($urandom)};
            txt = {txt, CHAR_SPACE};
            repeat ($urandom_range(0, 6))
                txt = {txt, 8'($urandom_range(8'h20, 8'h7E))};
            repeat ($urandom_range(1, 2))
                txt = {txt, eol[$urandom_range(0, 2)]};
        end
        for (int i = 0; i < meta_len; i++)
            image = {image, ($urandom_range(0, 11) == 0) ? 8'($urandom) : txt[i]};
        repeat (body_len)
            image = {image, 8'($urandom)};
        sum = CRC_INIT;
        foreach (image[i])
            sum = image_tag_board::crc_byte(sum, image[i]);
        sum = ~sum;
        if (flaw == FLAW_CRC)
            sum ^= 32'd1 << $urandom_range(0, 31);
        push_word(sum);
    endfunction

    task automatic send_word(logic [7:0] b, logic eos);
        if (!tail_part && !steady && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(b, eos);
        items_sent++;
    endtask

    task automatic send_image(int unsigned keep, int unsigned extra);
        for (int i = 0; i < keep; i++)
            send_word(image[i], 1'b0);
        repeat (extra)
            send_word(8'($urandom), 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_tags.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic set_checks(logic [31:0] id, logic [31:0] ver);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= CFG_EXPECTED_ID;
        cfg_data <= id;
        @(posedge clk);
        cfg_index <= CFG_EXPECTED_VERSION;
        cfg_data <= ver;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_EXPECTED_ID, id);
        sb.set_reg(CFG_EXPECTED_VERSION, ver);
    endtask

    initial
    begin
        flaw_e       flaw;
        int unsigned pick;
        int unsigned keep;
        int unsigned extra;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stream, bad id with a trailing byte, smallest good image
        send_word(8'hFF, 1'b1);
        make_image(FLAW_ID, 0, 0);
        send_image(5, 0);
        make_image(FLAW_NONE, 0, 0);
        send_image(image.size(), 0);

        for (int stage = 0; stage < 4; stage++)
        begin
            case (stage)
                0: set_checks('0, '0);
                1: set_checks('1, '1);
                2: set_checks($urandom, $urandom);
                default: set_checks(DEFAULT_ID, DEFAULT_VERSION);
            endcase
            while (items_sent < 30 + 225 * (stage + 1))
            begin
                tail_part = items_sent > 780;
                steady = $urandom_range(0, 4) == 0;
                pick = $urandom_range(0, 99);
                flaw = pick < 65 ? FLAW_NONE :
                       pick < 73 ? FLAW_CRC :
                       pick < 80 ? FLAW_ID :
                       pick < 87 ? FLAW_VERSION :
                       pick < 94 ? FLAW_LAYOUT : FLAW_NOISE;
                make_image(flaw,
                           $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 24),
                           $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 32));
                keep = image.size();
                if (pick < 10)
                    keep = $urandom_range(0, keep - 1);
                extra = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
                send_image(keep, extra);
            end
        end

        settle();
        repeat (4)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending_tags.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
